@@ sv/mlfq_pkg.sv @@
`default_nettype none

package mlfq_pkg;

    // slice registers are fixed by the register map
    localparam int SLICE_REGS = 4;
    localparam int LEVEL_W    = 2;
    localparam int LCOUNT_W   = 3;
    localparam int SLICE_W    = 16;
    localparam int PID_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        REQ_READY   = 2'd0,
        REQ_PREEMPT = 2'd1,
        REQ_EMPTY   = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_COUNT = 3'd0,
        CFG_SLICE_L0    = 3'd1,
        CFG_SLICE_L1    = 3'd2,
        CFG_SLICE_L2    = 3'd3,
        CFG_SLICE_L3    = 3'd4
    } t_cfg_idx;

    localparam logic RES_SELECT  = 1'b0;
    localparam logic RES_PREEMPT = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [PID_W-1:0]  proc_id;
        logic [PRIO_W-1:0] proc_priority;
        logic [TIME_W-1:0] change_time;
        logic              last_entry;
        logic [PRIO_W-1:0] cand_priority;
        logic [TIME_W-1:0] now_time;
    } t_req_beat;

    typedef struct packed {
        logic             result_kind;
        logic [PID_W-1:0] chosen_pid;
        logic             pid_valid;
        logic             do_preempt;
    } t_res_beat;

    typedef logic [SLICE_REGS-1:0][SLICE_W-1:0] t_slices;

    // clamp a priority to the levels in use (n is 1..4)
    function automatic logic [LEVEL_W-1:0] level_of(input logic [PRIO_W-1:0] prio,
                                                    input logic [LCOUNT_W-1:0] n);
        logic [LCOUNT_W-1:0] top_lvl;
        top_lvl = n - 3'd1;
        if (prio >= {{(PRIO_W-LCOUNT_W){1'b0}}, n}) begin
            return top_lvl[LEVEL_W-1:0];
        end
        return prio[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/mlfq_ifs.sv @@
`default_nettype none

interface mlfq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] proc_id;
    logic [7:0]  proc_priority;
    logic [31:0] change_time;
    logic        last_entry;
    logic [7:0]  cand_priority;
    logic [31:0] now_time;

    modport source (output valid, req_type, proc_id, proc_priority, change_time,
                    last_entry, cand_priority, now_time, input ready);
    modport sink (input valid, req_type, proc_id, proc_priority, change_time,
                  last_entry, cand_priority, now_time, output ready);
endinterface

interface mlfq_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] chosen_pid;
    logic        pid_valid;
    logic        do_preempt;

    modport source (output valid, result_kind, chosen_pid, pid_valid, do_preempt,
                    input ready);
    modport sink (input valid, result_kind, chosen_pid, pid_valid, do_preempt,
                  output ready);
endinterface

interface mlfq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/mlfq_select_and_preempt_unit.sv @@
// Multilevel feedback queue policy engine. Request beats arrive on i_req: a
// ready entry (one per queued process, last_entry on the final one), a
// preempt query, or a select on an empty queue. Priorities clamp to a level
// below the programmed level count (zero counts as one, capped at
// min(MAX_LEVELS, 4)). Selection keeps the best entry by lowest level, then
// oldest change time, then lowest pid, and answers on the final entry. A
// preempt query fires when the candidate sits on a lower level or the
// running process used up its level's slice (zero slice acts as one).
// A request that yields a result passes one input register and one result
// register, with the compare or the 32-bit elapsed-time subtract in between.
// A new request is taken every cycle unless a held result beat stalls the
// input register; the held best entry is updated in the same cycle as its
// compare, so back to back ready entries need no stall. Configuration writes
// are taken at any time and are meant for idle periods only.
`default_nettype none

module mlfq_select_and_preempt_unit #(
    parameter int MAX_LEVELS = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlfq_req_if.sink    i_req,
    mlfq_res_if.source  o_res,
    mlfq_cfg_if.sink    i_cfg
);

    // highest usable level count: bounded by the slice register file
    localparam int LEVEL_CAP = (MAX_LEVELS < mlfq_pkg::SLICE_REGS) ? MAX_LEVELS
                                                                 : mlfq_pkg::SLICE_REGS;

    // configuration registers
    logic [mlfq_pkg::LCOUNT_W-1:0] r_level_count;
    mlfq_pkg::t_slices             r_slices;

    // input stage
    logic                r_s1_valid;
    mlfq_pkg::t_req_beat r_s1;

    // result stage
    logic                r_res_valid;
    mlfq_pkg::t_res_beat r_res;
    mlfq_pkg::t_res_beat n_res;

    logic [mlfq_pkg::LCOUNT_W-1:0] levels;
    logic [mlfq_pkg::PID_W-1:0]    sel_pid;
    logic                          preempt;
    logic                          s1_emits;
    logic                          s1_adv;
    logic                          out_free;

    // config port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= 3'd1;
            r_slices      <= {mlfq_pkg::SLICE_REGS{16'd1}};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mlfq_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg.data[mlfq_pkg::LCOUNT_W-1:0];
                mlfq_pkg::CFG_SLICE_L0:    r_slices[0]   <= i_cfg.data;
                mlfq_pkg::CFG_SLICE_L1:    r_slices[1]   <= i_cfg.data;
                mlfq_pkg::CFG_SLICE_L2:    r_slices[2]   <= i_cfg.data;
                mlfq_pkg::CFG_SLICE_L3:    r_slices[3]   <= i_cfg.data;
                default: begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    // effective level count, 1..LEVEL_CAP
    always_comb begin
        if (r_level_count == '0) begin
            levels = 3'd1;
        end else if (r_level_count > 3'(LEVEL_CAP)) begin
            levels = 3'(LEVEL_CAP);
        end else begin
            levels = r_level_count;
        end
    end

    // does the staged beat produce a result beat
    always_comb begin
        case (r_s1.req_type)
            mlfq_pkg::REQ_READY:   s1_emits = r_s1.last_entry;
            mlfq_pkg::REQ_PREEMPT: s1_emits = 1'b1;
            mlfq_pkg::REQ_EMPTY:   s1_emits = 1'b1;
            default:               s1_emits = 1'b0;
        endcase
    end

    assign out_free    = !r_res_valid || o_res.ready;
    assign s1_adv      = r_s1_valid && (!s1_emits || out_free);
    assign i_req.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1.req_type      <= i_req.req_type;
            r_s1.proc_id       <= i_req.proc_id;
            r_s1.proc_priority <= i_req.proc_priority;
            r_s1.change_time   <= i_req.change_time;
            r_s1.last_entry    <= i_req.last_entry;
            r_s1.cand_priority <= i_req.cand_priority;
            r_s1.now_time      <= i_req.now_time;
        end
    end

    // best-entry tracker, updated once per retired beat
    mlfq_sel u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_beat   (r_s1),
        .i_levels (levels),
        .o_pid    (sel_pid)
    );

    // slice and level check
    mlfq_pre u_pre (
        .i_beat    (r_s1),
        .i_levels  (levels),
        .i_slices  (r_slices),
        .o_preempt (preempt)
    );

    // result beat assembly
    always_comb begin
        n_res = '0;
        case (r_s1.req_type)
            mlfq_pkg::REQ_READY: begin
                n_res.result_kind = mlfq_pkg::RES_SELECT;
                n_res.chosen_pid  = sel_pid;
                n_res.pid_valid   = 1'b1;
            end
            mlfq_pkg::REQ_PREEMPT: begin
                n_res.result_kind = mlfq_pkg::RES_PREEMPT;
                n_res.do_preempt  = preempt;
            end
            default: begin
                // empty queue: no pid chosen
                n_res.result_kind = mlfq_pkg::RES_SELECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s1_adv && s1_emits) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emits) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.result_kind = r_res.result_kind;
    assign o_res.chosen_pid  = r_res.chosen_pid;
    assign o_res.pid_valid   = r_res.pid_valid;
    assign o_res.do_preempt  = r_res.do_preempt;

endmodule

`default_nettype wire

@@ sv/mlfq_sel.sv @@
`default_nettype none

module mlfq_sel (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire mlfq_pkg::t_req_beat                 i_beat,
    input  wire logic [mlfq_pkg::LCOUNT_W-1:0]       i_levels,
    output logic      [mlfq_pkg::PID_W-1:0]          o_pid
);

    logic                            r_have;
    logic [mlfq_pkg::LEVEL_W-1:0]    r_best_lvl;
    logic [mlfq_pkg::TIME_W-1:0]     r_best_time;
    logic [mlfq_pkg::PID_W-1:0]      r_best_pid;

    logic [mlfq_pkg::LEVEL_W-1:0]    lvl;
    logic                            better;

    always_comb begin
        lvl    = mlfq_pkg::level_of(i_beat.proc_priority, i_levels);
        better = !r_have
              || (lvl < r_best_lvl)
              || ((lvl == r_best_lvl) && (i_beat.change_time < r_best_time))
              || ((lvl == r_best_lvl) && (i_beat.change_time == r_best_time)
                  && (i_beat.proc_id < r_best_pid));
        o_pid  = better ? i_beat.proc_id : r_best_pid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_lvl  <= '0;
            r_best_time <= '0;
            r_best_pid  <= '0;
        end else if (i_step) begin
            case (i_beat.req_type)
                mlfq_pkg::REQ_READY: begin
                    if (better) begin
                        r_best_lvl  <= lvl;
                        r_best_time <= i_beat.change_time;
                        r_best_pid  <= i_beat.proc_id;
                    end
                    // the final entry closes the selection
                    r_have <= !i_beat.last_entry;
                end
                mlfq_pkg::REQ_EMPTY: begin
                    r_have <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/mlfq_pre.sv @@
`default_nettype none

module mlfq_pre (
    input  wire mlfq_pkg::t_req_beat              i_beat,
    input  wire logic [mlfq_pkg::LCOUNT_W-1:0]    i_levels,
    input  wire mlfq_pkg::t_slices                i_slices,
    output logic                                  o_preempt
);

    logic [mlfq_pkg::LEVEL_W-1:0] run_lvl;
    logic [mlfq_pkg::LEVEL_W-1:0] cand_lvl;
    logic [mlfq_pkg::SLICE_W-1:0] slice;
    logic [mlfq_pkg::TIME_W-1:0]  elapsed;

    always_comb begin
        run_lvl  = mlfq_pkg::level_of(i_beat.proc_priority, i_levels);
        cand_lvl = mlfq_pkg::level_of(i_beat.cand_priority, i_levels);
        slice    = i_slices[run_lvl];
        // a zero slice behaves as one tick
        if (slice == '0) begin
            slice = 16'd1;
        end
        elapsed   = i_beat.now_time - i_beat.change_time;
        o_preempt = (cand_lvl < run_lvl)
                 || (elapsed >= {{(mlfq_pkg::TIME_W-mlfq_pkg::SLICE_W){1'b0}}, slice});
    end

endmodule

`default_nettype wire
